// File: sv/fcu_pkg.sv
// Shared types and constants for the complex FIR filter.
// No dependencies; imported by every module of the block.
package fcu_pkg;

   localparam int MAX_TAPS_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int TAP_INDEX_BITS  = 6;
   localparam int TAP_COUNT_BITS  = 7;
   localparam int MODE_BITS       = 2;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 7;

   // item commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE      = 2'd1;

   // mode codes; the spare code behaves as complex by complex
   localparam logic [MODE_BITS-1:0] MODE_REAL     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CPX_REAL = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CPX_CPX  = 2'd2;

   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 7'd64;
   localparam logic [MODE_BITS-1:0]      MODE_RESET      = MODE_CPX_CPX;

   // register stages in the MAC after the operand stage
   localparam int PIPE_DEPTH = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 clear;
      logic                 x_en;
      logic [MODE_BITS-1:0] mode;
   } mac_ctrl_type;

endpackage

// File: sv/fcu_cell.sv
// One stage of the delay line: holds one complex sample.
// Depends on fcu_pkg for the control struct.
module fcu_cell #(
   parameter int SAMPLE_BITS = fcu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcu_pkg::cell_ctrl_type        ctrl,
   input  logic signed [SAMPLE_BITS-1:0] shift_i,
   input  logic signed [SAMPLE_BITS-1:0] shift_q,
   input  logic signed [SAMPLE_BITS-1:0] rot_i,
   input  logic signed [SAMPLE_BITS-1:0] rot_q,
   output logic signed [SAMPLE_BITS-1:0] value_i,
   output logic signed [SAMPLE_BITS-1:0] value_q
);
   import fcu_pkg::*;

   logic signed [SAMPLE_BITS-1:0] val_i_ff, val_i_in;
   logic signed [SAMPLE_BITS-1:0] val_q_ff, val_q_in;

   // shift takes the newer neighbour, rotate the older one (the next cell, wrapping at the end)
   always_comb begin
      val_i_in = val_i_ff;
      val_q_in = val_q_ff;
      if (ctrl.shift) begin
         val_i_in = shift_i;
         val_q_in = shift_q;
      end else if (ctrl.rotate) begin
         val_i_in = rot_i;
         val_q_in = rot_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_i_ff <= '0;
         val_q_ff <= '0;
      end else begin
         val_i_ff <= val_i_in;
         val_q_ff <= val_q_in;
      end
   end

   assign value_i = val_i_ff;
   assign value_q = val_q_ff;

endmodule

// File: sv/fcu_mac.sv
// Shared complex multiply-accumulate with rounding and saturation.
// Depends on fcu_pkg; operands arrive one tap per cycle.
module fcu_mac #(
   parameter int MAX_TAPS    = fcu_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fcu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcu_pkg::mac_ctrl_type         ctrl,
   input  logic signed [SAMPLE_BITS-1:0] x_i,
   input  logic signed [SAMPLE_BITS-1:0] x_q,
   input  logic signed [SAMPLE_BITS-1:0] c_i,
   input  logic signed [SAMPLE_BITS-1:0] c_q,
   output logic signed [SAMPLE_BITS-1:0] out_i,
   output logic signed [SAMPLE_BITS-1:0] out_q,
   output logic                          saturated
);
   import fcu_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int FRAC  = SAMPLE_BITS - 1;
   localparam int P_W   = 2 * S;
   localparam int ACC_W = 2 * S + 2 + $clog2(MAX_TAPS);

   localparam logic signed [ACC_W:0] HALF  =
      {{(ACC_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
   localparam logic signed [ACC_W:0] MAX_V = {{(ACC_W + 2 - S){1'b0}}, {(S - 1){1'b1}}};
   localparam logic signed [ACC_W:0] MIN_V = {{(ACC_W + 2 - S){1'b1}}, {(S - 1){1'b0}}};

   // returns {clip, value}
   function automatic logic [S:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0] biased;
      logic signed [ACC_W:0] shifted;
      logic [S:0]            res;
      biased  = $signed({acc[ACC_W-1], acc}) + HALF;
      shifted = biased >>> FRAC;
      if (shifted > MAX_V) begin
         res = {1'b1, MAX_V[S-1:0]};
      end else if (shifted < MIN_V) begin
         res = {1'b1, MIN_V[S-1:0]};
      end else begin
         res = {1'b0, shifted[S-1:0]};
      end
      return res;
   endfunction

   logic signed [S-1:0]     x_i_ff, x_q_ff;
   logic                    en1_ff, en2_ff, en3_ff;
   logic signed [P_W-1:0]   p_rr_ff, p_qq_ff, p_rq_ff, p_qr_ff;
   logic signed [P_W:0]     pi_ff, pi_in, pq_ff, pq_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    cpx_taps, cpx_data;
   logic [S:0]              res_i, res_q;

   assign cpx_taps = (ctrl.mode != MODE_REAL) && (ctrl.mode != MODE_CPX_REAL);
   assign cpx_data = (ctrl.mode == MODE_CPX_REAL);

   always_comb begin
      pi_in = (P_W + 1)'(p_rr_ff);
      pq_in = '0;
      if (cpx_taps) begin
         pi_in = (P_W + 1)'(p_rr_ff) - (P_W + 1)'(p_qq_ff);
         pq_in = (P_W + 1)'(p_rq_ff) + (P_W + 1)'(p_qr_ff);
      end else if (cpx_data) begin
         pq_in = (P_W + 1)'(p_qr_ff);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (en3_ff) begin
         acc_in = acc_ff + ACC_W'(pi_ff);
      end
   end

   logic signed [ACC_W-1:0] accq_ff, accq_in;

   always_comb begin
      accq_in = accq_ff;
      if (ctrl.clear) begin
         accq_in = '0;
      end else if (en3_ff) begin
         accq_in = accq_ff + ACC_W'(pq_ff);
      end
   end

   // operand, product and combine stages
   always_ff @(posedge clock) begin
      x_i_ff  <= x_i;
      x_q_ff  <= x_q;
      p_rr_ff <= x_i_ff * c_i;
      p_qq_ff <= x_q_ff * c_q;
      p_rq_ff <= x_i_ff * c_q;
      p_qr_ff <= x_q_ff * c_i;
      pi_ff   <= pi_in;
      pq_ff   <= pq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en1_ff  <= 1'b0;
         en2_ff  <= 1'b0;
         en3_ff  <= 1'b0;
         acc_ff  <= '0;
         accq_ff <= '0;
      end else begin
         en1_ff  <= ctrl.x_en;
         en2_ff  <= en1_ff;
         en3_ff  <= en2_ff;
         acc_ff  <= acc_in;
         accq_ff <= accq_in;
      end
   end

   assign res_i     = round_sat(acc_ff);
   assign res_q     = round_sat(accq_ff);
   assign out_i     = res_i[S-1:0];
   assign out_q     = (ctrl.mode == MODE_REAL) ? '0 : res_q[S-1:0];
   assign saturated = res_i[S] | ((ctrl.mode != MODE_REAL) & res_q[S]);

endmodule

// File: sv/fir_filter_complex_unit.sv
// Complex direct-form FIR filter: delay-line cells, coefficient store, one shared MAC.
// Load item: accepted while idle, gives no result. Sample item: shifted into cell 0, then the
// delay line rotates once past the single complex MAC, the MAC pipeline drains and the result
// is registered when the output is free; the next item is taken only after that, back in idle.
// Synchronous active-high reset clears delay line, coefficients (valid bits), control registers.
// Depends on fcu_pkg, fcu_cell and fcu_mac.
module fir_filter_complex_unit #(
   parameter int MAX_TAPS    = fcu_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fcu_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [fcu_pkg::TAP_INDEX_BITS-1:0]    req_tap_index,
   input  logic signed [SAMPLE_BITS-1:0]         req_value_i,
   input  logic signed [SAMPLE_BITS-1:0]         req_value_q,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_i,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_q,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fcu_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [fcu_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import fcu_pkg::*;

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW = $clog2(MAX_TAPS + 1);
   localparam logic [CW-1:0] LAST_STEP  = CW'(MAX_TAPS - 1);
   localparam logic [CW-1:0] N_MAX      = CW'(MAX_TAPS);
   localparam logic [1:0]    DRAIN_LAST = 2'(PIPE_DEPTH - 1);

   state_type                   state_ff, state_in;
   logic [CW-1:0]               step_ff, step_in;
   logic [CW-1:0]               n_ff, n_in, n_eff, rd_diff;
   logic [1:0]                  drain_ff, drain_in;
   logic [TAP_COUNT_BITS-1:0]   csr_tap_count_ff, csr_tap_count_in;
   logic [MODE_BITS-1:0]        csr_mode_ff, csr_mode_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_out_i_ff, rsp_out_q_ff;
   logic                        rsp_sat_ff;

   logic          sample_acc, load_acc, idx_ok, out_free, out_load;
   logic [AW-1:0] waddr, raddr;
   cell_ctrl_type cell_ctrl;
   mac_ctrl_type  mac_ctrl;

   logic signed [SAMPLE_BITS-1:0] cell_i [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] cell_q [MAX_TAPS];

   logic signed [SAMPLE_BITS-1:0] coef_i_mem [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] coef_q_mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]           coef_vld_ff;
   logic signed [SAMPLE_BITS-1:0] coef_rd_i_ff, coef_rd_q_ff, coef_i, coef_q;
   logic                          coef_rd_vld_ff;

   logic signed [SAMPLE_BITS-1:0] mac_out_i, mac_out_q;
   logic                          mac_sat;

   assign sample_acc = req_valid & req_ready & (req_command == CMD_SAMPLE);
   assign load_acc   = req_valid & req_ready & (req_command == CMD_LOAD);
   assign idx_ok     = 32'(req_tap_index) < 32'(MAX_TAPS);
   assign waddr      = AW'(req_tap_index);
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign n_eff      = (32'(csr_tap_count_ff) > 32'(MAX_TAPS)) ? N_MAX
                                                               : CW'(csr_tap_count_ff);
   // tap n-1-j pairs with the sample cell 0 shows at step j
   assign rd_diff    = n_ff - CW'(1) - step_ff;
   assign raddr      = rd_diff[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (sample_acc) state_in = ST_RUN;
         ST_RUN:   if (step_ff == LAST_STEP) state_in = ST_DRAIN;
         ST_DRAIN: if (drain_ff == DRAIN_LAST) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready        = 1'b0;
      out_load         = 1'b0;
      cell_ctrl.shift  = 1'b0;
      cell_ctrl.rotate = 1'b0;
      mac_ctrl.clear   = 1'b0;
      mac_ctrl.x_en    = 1'b0;
      mac_ctrl.mode    = csr_mode_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cell_ctrl.shift = req_valid & (req_command == CMD_SAMPLE);
            mac_ctrl.clear  = req_valid & (req_command == CMD_SAMPLE);
         end
         ST_RUN: begin
            cell_ctrl.rotate = 1'b1;
            mac_ctrl.x_en    = step_ff < n_ff;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      step_in  = (state_ff == ST_RUN) ? step_ff + CW'(1) : '0;
      drain_in = (state_ff == ST_DRAIN) ? drain_ff + 2'd1 : 2'd0;
      n_in     = sample_acc ? n_eff : n_ff;
   end

   always_comb begin
      csr_tap_count_in = csr_tap_count_ff;
      csr_mode_in      = csr_mode_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TAP_COUNT) begin
            csr_tap_count_in = csr_data[TAP_COUNT_BITS-1:0];
         end else if (csr_index == CSR_MODE) begin
            csr_mode_in = csr_data[MODE_BITS-1:0];
         end
      end
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         drain_ff         <= '0;
         n_ff             <= '0;
         csr_tap_count_ff <= TAP_COUNT_RESET;
         csr_mode_ff      <= MODE_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         drain_ff         <= drain_in;
         n_ff             <= n_in;
         csr_tap_count_ff <= csr_tap_count_in;
         csr_mode_ff      <= csr_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_out_i_ff <= mac_out_i;
         rsp_out_q_ff <= mac_out_q;
         rsp_sat_ff   <= mac_sat;
      end
   end

   // coefficient store; entries never loaded read as zero
   always_ff @(posedge clock) begin
      if (load_acc && idx_ok) begin
         coef_i_mem[waddr] <= req_value_i;
         coef_q_mem[waddr] <= req_value_q;
      end
      coef_rd_i_ff <= coef_i_mem[raddr];
      coef_rd_q_ff <= coef_q_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff    <= '0;
         coef_rd_vld_ff <= 1'b0;
      end else begin
         if (load_acc && idx_ok) begin
            coef_vld_ff[waddr] <= 1'b1;
         end
         coef_rd_vld_ff <= coef_vld_ff[raddr];
      end
   end

   assign coef_i = coef_rd_vld_ff ? coef_rd_i_ff : '0;
   assign coef_q = coef_rd_vld_ff ? coef_rd_q_ff : '0;

   // delay line: cell 0 holds the newest sample and feeds the MAC
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      localparam int PREV = (k == 0) ? 0 : k - 1;
      localparam int NEXT = (k == MAX_TAPS - 1) ? 0 : k + 1;
      fcu_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (cell_ctrl),
         .shift_i ((k == 0) ? req_value_i : cell_i[PREV]),
         .shift_q ((k == 0) ? req_value_q : cell_q[PREV]),
         .rot_i   (cell_i[NEXT]),
         .rot_q   (cell_q[NEXT]),
         .value_i (cell_i[k]),
         .value_q (cell_q[k])
      );
   end

   fcu_mac #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .x_i       (cell_i[0]),
      .x_q       (cell_q[0]),
      .c_i       (coef_i),
      .c_q       (coef_q),
      .out_i     (mac_out_i),
      .out_q     (mac_out_q),
      .saturated (mac_sat)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_i     = rsp_out_i_ff;
   assign rsp_out_q     = rsp_out_q_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   a_sample_starts_run: assert property (@(posedge clock) disable iff (reset)
      sample_acc |=> (state_ff == ST_RUN) && (step_ff == '0))
      else $error("sample item did not start a pass at step zero");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> (state_ff == ST_IDLE))
      else $error("load item left idle");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff <= LAST_STEP) && (n_ff <= N_MAX))
      else $error("step or tap count out of range during a pass");
`endif

endmodule
